@@ src/multichannel_switch_debouncer_core_macros.svh @@
// Assertion macros for the switch debouncer bank.
`ifndef MULTICHANNEL_SWITCH_DEBOUNCER_CORE_MACROS_SVH
`define MULTICHANNEL_SWITCH_DEBOUNCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("debouncer check failed");
`define MSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("debouncer check failed");
`else
`define MSD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/msd_pkg.sv @@
// Types and constants shared by the switch debouncer bank.
`timescale 1ns / 1ps
package msd_pkg;

	localparam int CHANNELS = 12;
	localparam int BANK_W   = 12;
	localparam int CNT_W    = 8;
	localparam int IDX_W    = 4;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] MAX_COUNT_RST   = 8'd20;
	localparam logic [CNT_W-1:0] PRESS_THR_RST   = 8'd20;
	localparam logic [CNT_W-1:0] RELEASE_THR_RST = 8'd0;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_TAKE = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_COUNT   = 2'd0,
		REG_PRESS_THR   = 2'd1,
		REG_RELEASE_THR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [BANK_W-1:0]  raw_bits;
		logic [IDX_W-1:0]   channel_index;
	} in_item_t;

	typedef struct packed {
		logic [BANK_W-1:0]  pressed_bits;
		logic [BANK_W-1:0]  changed_bits;
		logic               press_taken;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] max_count;
		logic [CNT_W-1:0] press_threshold;
		logic [CNT_W-1:0] release_threshold;
	} cfg_t;

	// Per-lane control for one accepted transaction.
	typedef struct packed {
		logic tick;
		logic take;
		logic raw;
	} lane_ctl_t;

	// What one lane reports for the transaction in flight.
	typedef struct packed {
		logic pressed;
		logic changed;
		logic taken;
	} lane_res_t;

endpackage

@@ src/msd_lane.sv @@
// One debouncer channel: saturating integrator, hysteresis state and press latch.
`timescale 1ns / 1ps
module msd_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  msd_pkg::cfg_t     cfg,
	input  msd_pkg::lane_ctl_t ctl,
	output msd_pkg::lane_res_t res
);
	import msd_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             state_q;
	logic             latch_q;
	logic [CNT_W-1:0] count_next;
	logic             state_next;
	logic             rise;

	always_comb begin
		count_next = count_q;
		if (ctl.raw) begin
			if (count_q < cfg.max_count) begin
				count_next = count_q + 8'd1;
			end
		end else if (count_q != '0) begin
			count_next = count_q - 8'd1;
		end
	end

	// The thresholds are judged against the count after this tick's step.
	always_comb begin
		rise       = 1'b0;
		state_next = state_q;
		if (ctl.tick) begin
			if (!state_q && (count_next >= cfg.press_threshold)) begin
				rise       = 1'b1;
				state_next = 1'b1;
			end else if (state_q && (count_next <= cfg.release_threshold)) begin
				state_next = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			state_q <= 1'b0;
			latch_q <= 1'b0;
		end else begin
			if (ctl.tick) begin
				count_q <= count_next;
				state_q <= state_next;
			end
			if (rise) begin
				latch_q <= 1'b1;
			end else if (ctl.take) begin
				latch_q <= 1'b0;
			end
		end
	end

	assign res.pressed = state_next;
	assign res.changed = state_next ^ state_q;
	assign res.taken   = ctl.take & latch_q;

endmodule

@@ src/msd_merge.sv @@
// Gathers the lane results into one result transaction and holds it in the output register.
`timescale 1ns / 1ps
module msd_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  msd_pkg::lane_res_t   lane_res [msd_pkg::CHANNELS],
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output msd_pkg::out_item_t   out_data
);
	import msd_pkg::*;

	logic      out_valid_q;
	out_item_t out_data_q;
	out_item_t merged;

	always_comb begin
		merged = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			merged.pressed_bits[i] = lane_res[i].pressed;
			merged.changed_bits[i] = lane_res[i].changed;
			merged.press_taken     = merged.press_taken | lane_res[i].taken;
		end
	end

	// A new transaction may enter whenever the held result is leaving or absent.
	assign in_stall = out_valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= in_fire | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= merged;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ src/multichannel_switch_debouncer_core.sv @@
// Top level of the multichannel switch debouncer bank.
`timescale 1ns / 1ps
// Twelve switch debouncers update side by side, one lane per channel, from each
// tick transaction; a take transaction returns and clears one channel's press
// latch. One transaction is accepted every clock cycle unless a waiting result is
// stalled, and its result appears in the output register in the next cycle. The
// merging stage's output register holds that result, and each lane steps its
// counter as a tick transaction is accepted. The block accepts while its result
// waits, provided the waiting result is being taken in the same cycle.
// Configuration writes take effect on the next transaction; a write to an index
// above two is ignored.
`include "multichannel_switch_debouncer_core_macros.svh"
module multichannel_switch_debouncer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  msd_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output msd_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msd_pkg::CFG_W-1:0]         cfg_data
);
	import msd_pkg::*;

	localparam logic [IDX_W-1:0] CHAN_LIMIT = IDX_W'(CHANNELS);

	cfg_t      cfg_q;
	logic      in_fire;
	logic      take_fire;
	lane_ctl_t lane_ctl [CHANNELS];
	lane_res_t lane_res [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_count         <= MAX_COUNT_RST;
			cfg_q.press_threshold   <= PRESS_THR_RST;
			cfg_q.release_threshold <= RELEASE_THR_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_COUNT:   cfg_q.max_count         <= cfg_data;
				REG_PRESS_THR:   cfg_q.press_threshold   <= cfg_data;
				REG_RELEASE_THR: cfg_q.release_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_fire   = in_valid & ~in_stall;
	assign take_fire = in_fire & (in_data.opcode == OP_TAKE);

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		localparam logic [IDX_W-1:0] LANE_ID = IDX_W'(g);

		assign lane_ctl[g].tick = in_fire & (in_data.opcode == OP_TICK);
		assign lane_ctl[g].take = take_fire & (in_data.channel_index == LANE_ID);
		assign lane_ctl[g].raw  = in_data.raw_bits[g];

		msd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.ctl    (lane_ctl[g]),
			.res    (lane_res[g])
		);
	end

	msd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.lane_res  (lane_res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// A take transaction never reports a change of debounced state.
	`MSD_ASSERT_NEXT(a_take_no_change, clk, arst_n, take_fire, out_data.changed_bits == '0)
	// A take of a channel beyond the bank returns nothing.
	`MSD_ASSERT_NEXT(a_take_out_of_range, clk, arst_n, take_fire && (in_data.channel_index >= CHAN_LIMIT), !out_data.press_taken)
	// A latched press is only ever returned on a take, never alongside a change.
	`MSD_ASSERT_SAME(a_taken_only_on_take, clk, arst_n, out_valid && out_data.press_taken, out_data.changed_bits == '0)

endmodule
